[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL files.
// Depends on nothing; take in by `include inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define AST_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define AST_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/pfba_pkg.sv]
// Constants and codes of the paged fixed block allocator.
// Depends on nothing.
`default_nettype none
package pfba_pkg;
    localparam int PAGE_SLOTS      = 16;
    localparam int BLOCKS_PER_PAGE = 64;
    localparam int SLOT_W          = 4;
    localparam int IDX_W           = 6;
    localparam int BLK_W           = SLOT_W + IDX_W;
    localparam int LNK_W           = BLK_W + 1;
    localparam int TOTAL_BLOCKS    = PAGE_SLOTS * BLOCKS_PER_PAGE;
    localparam int CNT_W           = 5;
    localparam int FRESH_W         = 7;

    localparam logic [LNK_W-1:0] NIL = LNK_W'(TOTAL_BLOCKS);

    localparam logic [1:0] OP_ALLOC    = 2'd0;
    localparam logic [1:0] OP_FREE     = 2'd1;
    localparam logic [1:0] OP_PREALLOC = 2'd2;
    localparam logic [1:0] OP_COMPACT  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_PARTIAL = 2'd2;

    localparam logic [1:0] WH_NONE   = 2'd0;
    localparam logic [1:0] WH_ORPHAN = 2'd1;
    localparam logic [1:0] WH_FREE   = 2'd2;

    localparam logic CFG_PAGE_LIMIT = 1'b0;
    localparam logic CFG_BLOCKS     = 1'b1;
endpackage
`default_nettype wire

[hw/rtl/paged_fixed_block_allocator.sv]
// Top level of the paged fixed block allocator: sequencer, page slot state,
// link memories and result register. Depends on pfba_pkg and assert_macros.svh.
//
//  channel | dir | handshake          | beat
//  in      | in  | i_valid / o_stall  | opcode, block number, page count
//  out     | out | o_valid / i_stall  | granted block, status, pages, released
//  cfg     | in  | i_cfg_we           | register index, data
//
// Allocate: pops the orphan stack, else the free stack, else takes a fresh block, dropping
// exhausted queued pages and opening one if none is queued. Free: pushes a valid block on the
// orphan stack. Preallocate: opens up to the page count. Compact: moves orphans to the free
// stack, releases unused pages. Link memories: one read port each. One beat at a time.
// Reset is synchronous; link memories need no clearing pass.
// A stalled result holds; the next beat is taken once the sequencer is idle.
`default_nettype none
module paged_fixed_block_allocator (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_stall,
    input  wire  [1:0]                    i_opcode,
    input  wire  [pfba_pkg::BLK_W-1:0]    i_block_number,
    input  wire  [pfba_pkg::CNT_W-1:0]    i_page_count,
    output logic                          o_valid,
    input  wire                           i_stall,
    output logic [pfba_pkg::BLK_W-1:0]    o_granted_block,
    output logic [1:0]                    o_status,
    output logic [pfba_pkg::CNT_W-1:0]    o_pages_in_use,
    output logic [pfba_pkg::CNT_W-1:0]    o_pages_released,
    input  wire                           i_cfg_we,
    input  wire                           i_cfg_idx,
    input  wire  [pfba_pkg::FRESH_W-1:0]  i_cfg_data
);
    import pfba_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_POP, S_FRESH, S_FREE_CHK, S_PRE,
        S_CORPH, S_CMOVE, S_CSLOT, S_CBLK, S_CUNL, S_DONE
    } t_state;

    t_state                 r_state;
    logic [CNT_W-1:0]       r_page_limit;
    logic [FRESH_W-1:0]     r_blocks_in_page;

    logic [PAGE_SLOTS-1:0]  r_present;
    logic [FRESH_W-1:0]     r_fresh [PAGE_SLOTS];
    logic [FRESH_W-1:0]     r_used  [PAGE_SLOTS];
    logic [SLOT_W-1:0]      r_q     [PAGE_SLOTS];
    logic [CNT_W-1:0]       r_qlen;
    logic [LNK_W-1:0]       r_ftop, r_otop;
    logic [CNT_W-1:0]       r_total;

    logic [BLK_W-1:0]       r_b;
    logic                   r_src_free;
    logic [SLOT_W-1:0]      r_slot;
    logic [FRESH_W-1:0]     r_idx;
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       r_rel;
    logic [1:0]             r_status;
    logic [BLK_W-1:0]       r_grant;

    logic [LNK_W-1:0]       r_mem_next [TOTAL_BLOCKS];
    logic [LNK_W-1:0]       r_mem_prev [TOTAL_BLOCKS];
    logic [1:0]             r_mem_where [TOTAL_BLOCKS];
    logic [LNK_W-1:0]       r_rd_next, r_rd_prev;
    logic [1:0]             r_rd_where;

    logic [BLK_W-1:0]       rd_addr;
    logic                   nx_we, pv_we, wh_we;
    logic [BLK_W-1:0]       nx_wa, pv_wa, wh_wa;
    logic [LNK_W-1:0]       nx_wd, pv_wd;
    logic [1:0]             wh_wd;

    logic [CNT_W-1:0]       eff_limit;
    logic [FRESH_W-1:0]     eff_bip;
    logic [SLOT_W-1:0]      low_empty;
    logic                   any_empty, can_open, open_now;
    logic [SLOT_W-1:0]      head_s;
    logic [FRESH_W-1:0]     head_fresh;
    logic                   skip_head, release_now, free_ok;
    logic                   q_rm_en;
    logic [SLOT_W-1:0]      q_rm_pos, match_pos;
    logic                   match_ok;
    logic [SLOT_W-1:0]      n_q [PAGE_SLOTS];
    logic [CNT_W-1:0]       n_qlen;
    logic [SLOT_W-1:0]      b_slot;
    logic                   out_free;

    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !o_valid || !i_stall;
    assign b_slot   = r_b[BLK_W-1:IDX_W];

    always_comb begin
        if (r_page_limit == '0 || r_page_limit > CNT_W'(PAGE_SLOTS)) begin
            eff_limit = CNT_W'(PAGE_SLOTS);
        end else begin
            eff_limit = r_page_limit;
        end
        if (r_blocks_in_page == '0) begin
            eff_bip = FRESH_W'(1);
        end else if (r_blocks_in_page > FRESH_W'(BLOCKS_PER_PAGE)) begin
            eff_bip = FRESH_W'(BLOCKS_PER_PAGE);
        end else begin
            eff_bip = r_blocks_in_page;
        end
    end

    always_comb begin
        low_empty = '0;
        any_empty = 1'b0;
        for (int i = PAGE_SLOTS - 1; i >= 0; i--) begin
            if (!r_present[i]) begin
                low_empty = SLOT_W'(i);
                any_empty = 1'b1;
            end
        end
        match_pos = '0;
        match_ok  = 1'b0;
        for (int i = PAGE_SLOTS - 1; i >= 0; i--) begin
            if (CNT_W'(i) < r_qlen && r_q[i] == r_slot) begin
                match_pos = SLOT_W'(i);
                match_ok  = 1'b1;
            end
        end
    end

    assign can_open    = (r_total < eff_limit) && any_empty;
    assign head_s      = r_q[0];
    assign head_fresh  = r_fresh[head_s];
    assign skip_head   = (r_qlen != '0) && (head_fresh >= eff_bip);
    assign release_now = (r_state == S_CBLK) && (r_idx >= r_fresh[r_slot]);
    assign free_ok     = r_present[b_slot] && ({1'b0, r_b[IDX_W-1:0]} < r_fresh[b_slot])
                         && (r_rd_where == WH_NONE);
    assign open_now    = ((r_state == S_FRESH) && (r_qlen == '0) && can_open)
                      || ((r_state == S_PRE) && (r_cnt != '0) && can_open);

    always_comb begin
        q_rm_en  = 1'b0;
        q_rm_pos = '0;
        if (r_state == S_FRESH && r_qlen != '0
            && (skip_head || (head_fresh + FRESH_W'(1) >= eff_bip))) begin
            q_rm_en = 1'b1;
        end else if (release_now && match_ok) begin
            q_rm_en  = 1'b1;
            q_rm_pos = match_pos;
        end
        for (int i = 0; i < PAGE_SLOTS; i++) begin
            n_q[i] = r_q[i];
            if (q_rm_en && SLOT_W'(i) >= q_rm_pos && i < PAGE_SLOTS - 1) begin
                n_q[i] = r_q[i + 1];
            end
        end
        n_qlen = r_qlen;
        if (q_rm_en) begin
            n_qlen = r_qlen - CNT_W'(1);
        end
        if (open_now && r_qlen < CNT_W'(PAGE_SLOTS)) begin
            n_q[r_qlen[SLOT_W-1:0]] = low_empty;
            n_qlen = r_qlen + CNT_W'(1);
        end
    end

    always_comb begin
        rd_addr = r_b;
        nx_we = 1'b0; nx_wa = r_b; nx_wd = NIL;
        pv_we = 1'b0; pv_wa = r_b; pv_wd = NIL;
        wh_we = 1'b0; wh_wa = r_b; wh_wd = WH_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_opcode == OP_FREE) begin
                    rd_addr = i_block_number;
                end else if (r_otop != NIL) begin
                    rd_addr = r_otop[BLK_W-1:0];
                end else begin
                    rd_addr = r_ftop[BLK_W-1:0];
                end
            end
            S_POP: begin
                wh_we = 1'b1;
                if (r_src_free && r_rd_next != NIL) begin
                    pv_we = 1'b1;
                    pv_wa = r_rd_next[BLK_W-1:0];
                end
            end
            S_FRESH: begin
                if (!skip_head && r_qlen != '0) begin
                    wh_we = 1'b1;
                    wh_wa = {head_s, head_fresh[IDX_W-1:0]};
                end
            end
            S_FREE_CHK: begin
                if (free_ok) begin
                    wh_we = 1'b1;
                    wh_wd = WH_ORPHAN;
                    nx_we = 1'b1;
                    nx_wd = r_otop;
                end
            end
            S_CORPH: begin
                rd_addr = r_otop[BLK_W-1:0];
                if (r_otop != NIL) begin
                    pv_we = 1'b1;
                    pv_wa = r_otop[BLK_W-1:0];
                end
            end
            S_CMOVE: begin
                wh_we = 1'b1;
                wh_wd = WH_FREE;
                nx_we = 1'b1;
                nx_wd = r_ftop;
                if (r_ftop != NIL) begin
                    pv_we = 1'b1;
                    pv_wa = r_ftop[BLK_W-1:0];
                    pv_wd = {1'b0, r_b};
                end
            end
            S_CBLK: begin
                rd_addr = {r_slot, r_idx[IDX_W-1:0]};
            end
            S_CUNL: begin
                if (r_rd_where == WH_FREE) begin
                    wh_we = 1'b1;
                    if (r_rd_prev != NIL) begin
                        nx_we = 1'b1;
                        nx_wa = r_rd_prev[BLK_W-1:0];
                        nx_wd = r_rd_next;
                    end
                    if (r_rd_next != NIL) begin
                        pv_we = 1'b1;
                        pv_wa = r_rd_next[BLK_W-1:0];
                        pv_wd = r_rd_prev;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (nx_we) begin
            r_mem_next[nx_wa] <= nx_wd;
        end
        r_rd_next <= r_mem_next[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (pv_we) begin
            r_mem_prev[pv_wa] <= pv_wd;
        end
        r_rd_prev <= r_mem_prev[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (wh_we) begin
            r_mem_where[wh_wa] <= wh_wd;
        end
        r_rd_where <= r_mem_where[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_page_limit     <= CNT_W'(16);
            r_blocks_in_page <= FRESH_W'(64);
            r_present        <= '0;
            r_qlen           <= '0;
            r_ftop           <= NIL;
            r_otop           <= NIL;
            r_total          <= '0;
            o_valid          <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_PAGE_LIMIT) begin
                    r_page_limit <= i_cfg_data[CNT_W-1:0];
                end else begin
                    r_blocks_in_page <= i_cfg_data;
                end
            end
            if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            r_q    <= n_q;
            r_qlen <= n_qlen;
            if (open_now) begin
                r_present[low_empty] <= 1'b1;
                r_fresh[low_empty]   <= '0;
                r_used[low_empty]    <= '0;
                r_total              <= r_total + CNT_W'(1);
            end
            unique case (r_state)
                S_IDLE: begin
                    r_grant  <= '0;
                    r_status <= ST_OK;
                    r_rel    <= '0;
                    r_slot   <= '0;
                    r_b      <= i_block_number;
                    r_cnt    <= i_page_count;
                    if (i_valid) begin
                        unique case (i_opcode)
                            OP_ALLOC: begin
                                if (r_otop != NIL) begin
                                    r_b        <= r_otop[BLK_W-1:0];
                                    r_src_free <= 1'b0;
                                    r_state    <= S_POP;
                                end else if (r_ftop != NIL) begin
                                    r_b        <= r_ftop[BLK_W-1:0];
                                    r_src_free <= 1'b1;
                                    r_state    <= S_POP;
                                end else begin
                                    r_state <= S_FRESH;
                                end
                            end
                            OP_FREE:     r_state <= S_FREE_CHK;
                            OP_PREALLOC: r_state <= S_PRE;
                            OP_COMPACT:  r_state <= S_CORPH;
                        endcase
                    end
                end
                S_POP: begin
                    r_grant <= r_b;
                    if (r_src_free) begin
                        r_ftop <= r_rd_next;
                        if (r_used[b_slot] < FRESH_W'(BLOCKS_PER_PAGE)) begin
                            r_used[b_slot] <= r_used[b_slot] + FRESH_W'(1);
                        end
                    end else begin
                        r_otop <= r_rd_next;
                    end
                    r_state <= S_DONE;
                end
                S_FRESH: begin
                    if (r_qlen == '0) begin
                        if (!can_open) begin
                            r_status <= ST_EMPTY;
                            r_state  <= S_DONE;
                        end
                    end else if (!skip_head) begin
                        r_grant         <= {head_s, head_fresh[IDX_W-1:0]};
                        r_fresh[head_s] <= head_fresh + FRESH_W'(1);
                        if (r_used[head_s] < FRESH_W'(BLOCKS_PER_PAGE)) begin
                            r_used[head_s] <= r_used[head_s] + FRESH_W'(1);
                        end
                        r_state <= S_DONE;
                    end
                end
                S_FREE_CHK: begin
                    if (free_ok) begin
                        r_otop <= {1'b0, r_b};
                    end
                    r_state <= S_DONE;
                end
                S_PRE: begin
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end else if (can_open) begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end else begin
                        r_status <= ST_PARTIAL;
                        r_state  <= S_DONE;
                    end
                end
                S_CORPH: begin
                    if (r_otop == NIL) begin
                        r_state <= S_CSLOT;
                    end else begin
                        r_b     <= r_otop[BLK_W-1:0];
                        r_state <= S_CMOVE;
                    end
                end
                S_CMOVE: begin
                    r_otop <= r_rd_next;
                    r_ftop <= {1'b0, r_b};
                    if (r_used[b_slot] != '0) begin
                        r_used[b_slot] <= r_used[b_slot] - FRESH_W'(1);
                    end
                    r_state <= S_CORPH;
                end
                S_CSLOT: begin
                    r_idx <= '0;
                    if (r_present[r_slot] && r_used[r_slot] == '0) begin
                        r_state <= S_CBLK;
                    end else if (r_slot == SLOT_W'(PAGE_SLOTS - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_slot <= r_slot + SLOT_W'(1);
                    end
                end
                S_CBLK: begin
                    r_b <= {r_slot, r_idx[IDX_W-1:0]};
                    if (release_now) begin
                        r_present[r_slot] <= 1'b0;
                        if (r_total != '0) begin
                            r_total <= r_total - CNT_W'(1);
                        end
                        r_rel <= r_rel + CNT_W'(1);
                        if (r_slot == SLOT_W'(PAGE_SLOTS - 1)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_slot  <= r_slot + SLOT_W'(1);
                            r_state <= S_CSLOT;
                        end
                    end else begin
                        r_state <= S_CUNL;
                    end
                end
                S_CUNL: begin
                    if (r_rd_where == WH_FREE && r_rd_prev == NIL) begin
                        r_ftop <= r_rd_next;
                    end
                    r_idx   <= r_idx + FRESH_W'(1);
                    r_state <= S_CBLK;
                end
                S_DONE: begin
                    if (out_free) begin
                        o_valid          <= 1'b1;
                        o_granted_block  <= r_grant;
                        o_status         <= r_status;
                        o_pages_in_use   <= r_total;
                        o_pages_released <= r_rel;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `AST_IMP(a_total_max, i_clk, i_rst_n, 1'b1, r_total <= CNT_W'(PAGE_SLOTS))
    `AST_IMP(a_queue_le_total, i_clk, i_rst_n, 1'b1, r_qlen <= r_total)
    `AST_IMP(a_otop_range, i_clk, i_rst_n, r_otop != NIL, r_otop[BLK_W] == 1'b0)
    `AST_NXT(a_done_emits, i_clk, i_rst_n, r_state == S_DONE && out_free, o_valid)
endmodule
`default_nettype wire
